// ===== hw/rtl/awt_pkg.sv =====
// Package for the adjacency weight table: payload structs, sequencer states,
// result kinds, the preset graph and the table index helpers.
// No dependencies.
package awt_pkg;

    localparam int VERTICES  = 6;
    localparam int DEPTH     = VERTICES * VERTICES;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int PRESET_N  = 8;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_NONE  = 2'd1,
        KIND_RANGE = 2'd2
    } kind_t;

    typedef struct packed {
        logic       command;
        logic [3:0] vertex_a;
        logic [3:0] vertex_b;
        logic [7:0] weight;
    } cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] neighbour;
        logic [7:0] edge_weight;
        logic       last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_A,
        ST_SET_B,
        ST_RD,
        ST_CHK,
        ST_FINAL
    } state_t;

    // Table access request from the sequencer; row and column are zero based.
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [3:0] row;
        logic [3:0] col;
        logic [7:0] wdata;
    } store_req_t;

    // Preset edges, one based, each looked up in both directions.
    localparam logic [3:0] PRESET_A [PRESET_N] = '{4'd1, 4'd1, 4'd1, 4'd1,
                                                   4'd2, 4'd3, 4'd5, 4'd5};
    localparam logic [3:0] PRESET_B [PRESET_N] = '{4'd2, 4'd3, 4'd4, 4'd6,
                                                   4'd3, 4'd5, 4'd5, 4'd6};
    localparam logic [7:0] PRESET_W [PRESET_N] = '{8'd1, 8'd1, 8'd1, 8'd2,
                                                   8'd1, 8'd4, 8'd4, 8'd3};

    function automatic logic in_range(input logic [3:0] v);
        return (v != 4'd0) && (v <= 4'(VERTICES));
    endfunction

    function automatic logic [IDX_W-1:0] make_idx(input logic [3:0] r, input logic [3:0] c);
        logic [7:0] p;
        p = 8'(r) * 8'(VERTICES) + 8'(c);
        return p[IDX_W-1:0];
    endfunction

    // Weight that the preset graph puts at zero-based row r, column c.
    function automatic logic [7:0] preset_weight(input logic [3:0] r, input logic [3:0] c);
        logic [3:0] rv;
        logic [3:0] cv;
        logic [7:0] w;
        rv = r + 4'd1;
        cv = c + 4'd1;
        w  = 8'd0;
        for (int i = 0; i < PRESET_N; i++) begin
            if ((rv == PRESET_A[i] && cv == PRESET_B[i]) ||
                (rv == PRESET_B[i] && cv == PRESET_A[i])) begin
                w = PRESET_W[i];
            end
        end
        return w;
    endfunction

endpackage

// ===== hw/rtl/adjacency_weight_table_top.sv =====
// Top level of the adjacency weight table: sequencer plus weight storage.
// Depends on awt_pkg, awt_seq, awt_store.
//
// Usage:
//   s_ channel takes one request: command (query or set), vertex_a,
//   vertex_b and weight. m_ channel returns results: kind, neighbour,
//   edge_weight and last, where last marks the final result of a request.
//   A set in range writes both directions of the edge and returns nothing.
//   A query scans its row one column per read of the table RAM (a read
//   state and a check state per column); neighbours come out in rising
//   order, an empty row gives one "none" result. A vertex out of range
//   gives one error result and leaves the table alone. s_ready is high only
//   while the sequencer is idle; one request is worked on at a time. The
//   result register lets a new request in while the last result still
//   waits; a stalled receiver holds the scan once the result register and
//   the pending neighbour are both full and another neighbour is found.
//   Reset returns the table to the preset graph at once through per-entry
//   written flags; no clearing pass is needed.
module adjacency_weight_table_top
    import awt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  cmd_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    store_req_t req;
    logic [7:0] rd_weight;

    awt_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .req       (req),
        .rd_weight (rd_weight)
    );

    awt_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .rd_weight (rd_weight)
    );

endmodule

// ===== hw/rtl/awt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module awt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 36
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/awt_store.sv =====
// Weight table storage: RAM plus one written flag per entry; an unwritten
// entry reads as the preset graph. Depends on awt_pkg and awt_ram.
module awt_store
    import awt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  store_req_t req,
    output logic [7:0] rd_weight
);

    logic [DEPTH-1:0] written_reg;
    logic [DEPTH-1:0] written_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [3:0]       rd_row_reg;
    logic [3:0]       rd_col_reg;
    logic [IDX_W-1:0] req_idx;
    logic [7:0]       ram_q;

    assign req_idx = make_idx(req.row, req.col);

    always_comb begin
        written_next = written_reg;
        if (req.wr_en) begin
            written_next[req_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else begin
            written_reg <= written_next;
        end
        if (req.rd_en) begin
            rd_idx_reg <= req_idx;
            rd_row_reg <= req.row;
            rd_col_reg <= req.col;
        end
    end

    awt_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.wr_en),
        .waddr (req_idx),
        .wdata (req.wdata),
        .re    (req.rd_en),
        .raddr (req_idx),
        .rdata (ram_q)
    );

    assign rd_weight = written_reg[rd_idx_reg] ? ram_q
                                               : preset_weight(rd_row_reg, rd_col_reg);

endmodule

// ===== hw/rtl/awt_seq.sv =====
// Command sequencer: decodes requests, drives table writes and the row scan,
// and holds one pending neighbour plus the result register. Depends on awt_pkg.
module awt_seq
    import awt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  cmd_t       s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_data,
    output store_req_t req,
    input  logic [7:0] rd_weight
);

    state_t     state_reg, state_next;
    logic [3:0] row_reg, row_next;
    logic [3:0] col_reg, col_next;
    logic [7:0] w_reg, w_next;
    res_t       pend_reg, pend_next;
    logic       pend_valid_reg, pend_valid_next;
    res_t       out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic out_free;
    logic chk_go;
    logic bad_req;
    logic col_last;
    res_t found;

    assign out_free = !out_valid_reg || m_ready;
    // A new neighbour can only displace the pending one when the output is free.
    assign chk_go   = (rd_weight == 8'd0) || !pend_valid_reg || out_free;
    assign bad_req  = !in_range(s_data.vertex_a) ||
                      (s_data.command == CMD_SET && !in_range(s_data.vertex_b));
    assign col_last = (col_reg == 4'(VERTICES - 1));
    assign found    = '{kind: KIND_ENTRY, neighbour: col_reg + 4'd1,
                        edge_weight: rd_weight, last: 1'b0};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (bad_req) begin
                        state_next = ST_FINAL;
                    end else if (s_data.command == CMD_SET) begin
                        state_next = ST_SET_A;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_SET_A: state_next = ST_SET_B;
            ST_SET_B: state_next = ST_IDLE;
            ST_RD:    state_next = ST_CHK;
            ST_CHK: begin
                if (chk_go) begin
                    state_next = col_last ? ST_FINAL : ST_RD;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        row_next        = row_reg;
        col_next        = col_reg;
        w_next          = w_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        req             = '{wr_en: 1'b0, rd_en: 1'b0, row: row_reg, col: col_reg,
                            wdata: w_reg};
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    row_next = s_data.vertex_a - 4'd1;
                    col_next = (s_data.command == CMD_SET) ? s_data.vertex_b - 4'd1 : 4'd0;
                    w_next   = s_data.weight;
                    if (bad_req) begin
                        pend_next       = '{kind: KIND_RANGE, neighbour: 4'd0,
                                            edge_weight: 8'd0, last: 1'b1};
                        pend_valid_next = 1'b1;
                    end else begin
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_SET_A: begin
                req.wr_en = 1'b1;
            end
            ST_SET_B: begin
                // mirror direction; a self loop rewrites the same entry
                req.wr_en = 1'b1;
                req.row   = col_reg;
                req.col   = row_reg;
            end
            ST_RD: begin
                req.rd_en = 1'b1;
            end
            ST_CHK: begin
                if (chk_go) begin
                    if (rd_weight != 8'd0) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_next.last  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = found;
                        pend_valid_next = 1'b1;
                    end
                    if (!col_last) begin
                        col_next = col_reg + 4'd1;
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end else begin
                        out_next = '{kind: KIND_NONE, neighbour: 4'd0,
                                     edge_weight: 8'd0, last: 1'b1};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        row_reg  <= row_next;
        col_reg  <= col_next;
        w_reg    <= w_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

// ===== hw/rtl/awt_checker.sv =====
// Port-level checks for the adjacency weight table, bound to the top level.
// Depends on awt_pkg and adjacency_weight_table_top.
module awt_checker
    import awt_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input cmd_t s_data,
    input logic m_valid,
    input logic m_ready,
    input res_t m_data
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request dropped or changed before it was taken");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while still busy");

    a_entry_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_ENTRY |->
            m_data.neighbour != 4'd0 && m_data.neighbour <= 4'(VERTICES) &&
            m_data.edge_weight != 8'd0)
        else $error("neighbour entry with bad vertex or zero weight");

    a_single_results: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_NONE || m_data.kind == KIND_RANGE) |->
            m_data.last && m_data.neighbour == 4'd0 && m_data.edge_weight == 8'd0)
        else $error("none or range result not a lone final result");

endmodule

bind adjacency_weight_table_top awt_checker u_awt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
